@@ design/zsn_pkg.sv @@
`default_nettype none

package zsn_pkg;

    // Default depth of the sample store.
    localparam int MAX_SAMPLES_DEF = 32;

    // Fixed field widths.
    localparam int SAMPLE_W = 32;
    localparam int TOTAL_W  = 38;
    localparam int ACC_W    = 72;
    localparam int DIV_N_W  = 72;
    localparam int DIV_D_W  = 32;
    localparam int SQRT_W   = 64;
    localparam int ROOT_W   = 32;

    // Saturation limits of the Q8.16 z-score.
    localparam logic signed [23:0] Z_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] Z_MIN = 24'sh800000;

    typedef struct packed {
        logic [31:0] sample;
        logic        final_sample;
    } t_in_item;

    typedef struct packed {
        logic [23:0] zscore;
        logic [4:0]  sample_index;
        logic [31:0] mean_value;
        logic [31:0] std_dev;
        logic [47:0] variance_value;
        logic        degenerate;
        logic        overflowed;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quot;
        logic [DIV_D_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ design/zscore_normalizer.sv @@
// Channel  | Direction | Handshake                 | Payload
// input    | in        | i_in_valid / o_in_ready   | i_in_data  (zsn_pkg::t_in_item)
// output   | out       | o_out_valid / i_out_ready | o_out_data (zsn_pkg::t_out_item)
//
// Samples load one per cycle; after the last one the block stops taking input.
// The mean divide runs 72 divider steps, then each sample's squared deviation passes
// address, data, multiply and accumulate states, then the variance divide and the square root run.
// Each result then mostly waits on the shared divider, which is skipped at zero spread.
// Reset is synchronous and active low; the store needs no clearing.
// A stalled output holds the block in place until the transfer completes.
`default_nettype none

module zscore_normalizer #(
    parameter int MAX_SAMPLES = zsn_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire zsn_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output zsn_pkg::t_out_item       o_out_data
);

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_MEAN_GO   = 4'd1;
    localparam logic [3:0] S_MEAN_WAIT = 4'd2;
    localparam logic [3:0] S_VAR_ADDR  = 4'd3;
    localparam logic [3:0] S_VAR_DATA  = 4'd4;
    localparam logic [3:0] S_VAR_MUL   = 4'd5;
    localparam logic [3:0] S_VAR_ACC   = 4'd6;
    localparam logic [3:0] S_VDIV_GO   = 4'd7;
    localparam logic [3:0] S_VDIV_WAIT = 4'd8;
    localparam logic [3:0] S_SQRT_GO   = 4'd9;
    localparam logic [3:0] S_SQRT_WAIT = 4'd10;
    localparam logic [3:0] S_OUT_ADDR  = 4'd11;
    localparam logic [3:0] S_OUT_DATA  = 4'd12;
    localparam logic [3:0] S_ZDIV_GO   = 4'd13;
    localparam logic [3:0] S_ZDIV_WAIT = 4'd14;
    localparam logic [3:0] S_EMIT      = 4'd15;

    logic [3:0]                       r_state;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    r_idx;
    logic signed [zsn_pkg::TOTAL_W-1:0] r_total;
    logic                             r_drop;
    logic                             r_mean_neg;
    logic [31:0]                      r_mean;
    logic [31:0]                      r_mag;
    logic                             r_neg;
    logic [63:0]                      r_prod;
    logic [zsn_pkg::ACC_W-1:0]        r_acc;
    logic [63:0]                      r_var;
    logic [31:0]                      r_sd;
    logic [47:0]                      r_var48;
    logic [23:0]                      r_z;

    logic                             in_xfer;
    logic                             out_xfer;
    logic                             store_ok;
    logic [31:0]                      rdata;
    logic [39:0]                      mean_num;
    logic [39:0]                      mean_abs;
    logic [40:0]                      mean_q;
    logic [40:0]                      mean_s;
    logic [32:0]                      dev;
    logic [32:0]                      dev_abs;
    logic [48:0]                      var_rnd;
    logic [63:0]                      zq;
    logic [CW:0]                      idx_next;
    logic [31:0]                      idx_wide;
    logic                             sqrt_done;
    logic [31:0]                      sqrt_root;
    zsn_pkg::t_div_req                div_req;
    zsn_pkg::t_div_rsp                div_rsp;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_EMIT);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;
    assign store_ok    = r_count < CW'(MAX_SAMPLES);
    assign idx_next    = {1'b0, r_idx} + (CW+1)'(1);

    zsn_ram #(
        .WIDTH (zsn_pkg::SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_xfer && store_ok),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_data.sample),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    // Mean numerator 2*total + n; a negative numerator rounds its magnitude up,
    // so that the signed quotient is floored.
    always_comb begin
        mean_num = {r_total[zsn_pkg::TOTAL_W-1], r_total, 1'b0} + 40'(r_count);
        mean_abs = mean_num[39] ? 40'(-mean_num) : mean_num;
        mean_q   = {1'b0, div_rsp.quot[39:0]}
                 + 41'(r_mean_neg && (div_rsp.rem != '0));
        mean_s   = r_mean_neg ? 41'(-mean_q) : mean_q;
    end

    // Deviation of the sample just read from the mean.
    always_comb begin
        dev     = {rdata[31], rdata} - {r_mean[31], r_mean};
        dev_abs = dev[32] ? 33'(-dev) : dev;
    end

    assign var_rnd  = {1'b0, r_var[63:16]} + 49'(r_var[15]);
    assign zq       = div_rsp.quot[63:0];
    assign idx_wide = 32'(r_idx);

    // Requests to the shared divider.
    always_comb begin
        div_req = '0;
        unique case (r_state)
            S_MEAN_GO: begin
                div_req.start = 1'b1;
                div_req.num   = zsn_pkg::DIV_N_W'(mean_abs);
                div_req.den   = 32'({r_count, 1'b0});
            end
            S_VDIV_GO: begin
                div_req.start = 1'b1;
                div_req.num   = r_acc;
                div_req.den   = 32'(r_count);
            end
            S_ZDIV_GO: begin
                div_req.start = 1'b1;
                div_req.num   = zsn_pkg::DIV_N_W'({1'b0, r_mag, 16'd0} + 49'(r_sd[31:1]));
                div_req.den   = r_sd;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    zsn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    zsn_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SQRT_GO),
        .i_radicand (r_var),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // Sequencer and load state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_idx   <= '0;
            r_total <= '0;
            r_drop  <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (store_ok) begin
                            r_count <= r_count + CW'(1);
                            r_total <= r_total
                                + zsn_pkg::TOTAL_W'($signed(i_in_data.sample));
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_in_data.final_sample) begin
                            r_state <= S_MEAN_GO;
                        end
                    end
                end
                S_MEAN_GO:   r_state <= S_MEAN_WAIT;
                S_MEAN_WAIT: begin
                    if (div_rsp.done) begin
                        r_idx   <= '0;
                        r_state <= S_VAR_ADDR;
                    end
                end
                S_VAR_ADDR:  r_state <= S_VAR_DATA;
                S_VAR_DATA:  r_state <= S_VAR_MUL;
                S_VAR_MUL:   r_state <= S_VAR_ACC;
                S_VAR_ACC: begin
                    if (idx_next == {1'b0, r_count}) begin
                        r_idx   <= '0;
                        r_state <= S_VDIV_GO;
                    end else begin
                        r_idx   <= idx_next[CW-1:0];
                        r_state <= S_VAR_ADDR;
                    end
                end
                S_VDIV_GO:   r_state <= S_VDIV_WAIT;
                S_VDIV_WAIT: begin
                    if (div_rsp.done) begin
                        r_state <= S_SQRT_GO;
                    end
                end
                S_SQRT_GO:   r_state <= S_SQRT_WAIT;
                S_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        r_state <= S_OUT_ADDR;
                    end
                end
                S_OUT_ADDR:  r_state <= S_OUT_DATA;
                S_OUT_DATA:  r_state <= (r_sd == '0) ? S_EMIT : S_ZDIV_GO;
                S_ZDIV_GO:   r_state <= S_ZDIV_WAIT;
                S_ZDIV_WAIT: begin
                    if (div_rsp.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_xfer) begin
                        if (idx_next == {1'b0, r_count}) begin
                            r_count <= '0;
                            r_total <= '0;
                            r_drop  <= 1'b0;
                            r_idx   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= idx_next[CW-1:0];
                            r_state <= S_OUT_ADDR;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MEAN_GO) begin
            r_mean_neg <= mean_num[39];
            r_acc      <= '0;
        end
        if (r_state == S_MEAN_WAIT && div_rsp.done) begin
            if ($signed(mean_s) > 41'sh0007FFFFFFF) begin
                r_mean <= 32'h7FFF_FFFF;
            end else if ($signed(mean_s) < -41'sh00080000000) begin
                r_mean <= 32'h8000_0000;
            end else begin
                r_mean <= mean_s[31:0];
            end
        end
        if (r_state == S_VAR_DATA || r_state == S_OUT_DATA) begin
            r_mag <= dev_abs[31:0];
            r_neg <= dev[32];
        end
        if (r_state == S_OUT_DATA) begin
            r_z <= '0;
        end
        if (r_state == S_VAR_MUL) begin
            r_prod <= r_mag * r_mag;
        end
        if (r_state == S_VAR_ACC) begin
            r_acc <= r_acc + zsn_pkg::ACC_W'(r_prod);
        end
        if (r_state == S_VDIV_WAIT && div_rsp.done) begin
            r_var <= div_rsp.quot[63:0];
        end
        if (r_state == S_SQRT_WAIT && sqrt_done) begin
            r_sd    <= sqrt_root;
            r_var48 <= var_rnd[48] ? 48'hFFFF_FFFF_FFFF : var_rnd[47:0];
        end
        // Round-to-nearest quotient, then saturate to Q8.16.
        if (r_state == S_ZDIV_WAIT && div_rsp.done) begin
            if (r_neg) begin
                r_z <= (zq > 64'd8388608) ? zsn_pkg::Z_MIN : 24'(-zq);
            end else begin
                r_z <= (zq > 64'd8388607) ? zsn_pkg::Z_MAX : zq[23:0];
            end
        end
    end

    // Result fields are registers or decoded from them, so they hold while the transfer waits.
    always_comb begin
        o_out_data.zscore         = r_z;
        o_out_data.sample_index   = idx_wide[4:0];
        o_out_data.mean_value     = r_mean;
        o_out_data.std_dev        = r_sd;
        o_out_data.variance_value = r_var48;
        o_out_data.degenerate     = (r_sd == '0);
        o_out_data.overflowed     = r_drop;
        o_out_data.last_result    = (idx_next == {1'b0, r_count});
    end

    // Input and output are never offered together.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output both active");

    // The fill count never passes the store depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    // A degenerate result always carries a zero z-score.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.degenerate) |-> (o_out_data.zscore == '0))
        else $error("degenerate result with non-zero z-score");

    // Once a run is under way, a result is never offered with an empty set.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_count != '0))
        else $error("result offered with empty sample set");

endmodule

`default_nettype wire

@@ design/zsn_ram.sv @@
`default_nettype none

module zsn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/zsn_div.sv @@
`default_nettype none

module zsn_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire zsn_pkg::t_div_req i_req,
    output zsn_pkg::t_div_rsp      o_rsp
);

    localparam int NW = zsn_pkg::DIV_N_W;
    localparam int DW = zsn_pkg::DIV_D_W;

    logic          r_busy;
    logic [6:0]    r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic          r_done;
    logic [DW:0]   shifted;
    logic          fits;
    logic [DW:0]   diff;

    // One restoring step: bring down the next dividend bit and try the divisor.
    always_comb begin
        shifted = {r_rem, r_num[NW-1]};
        fits    = shifted >= {1'b0, r_den};
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in behind the dividend.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], fits};
            r_rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

@@ design/zsn_sqrt.sv @@
`default_nettype none

module zsn_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [zsn_pkg::SQRT_W-1:0]    i_radicand,
    output logic                               o_done,
    output logic      [zsn_pkg::ROOT_W-1:0]    o_root
);

    localparam int VW = zsn_pkg::SQRT_W;
    localparam int RW = zsn_pkg::ROOT_W;

    logic          r_busy;
    logic [5:0]    r_cnt;
    logic [VW-1:0] r_rad;
    logic [RW+2:0] r_rem;
    logic [RW-1:0] r_root;
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic          fits;

    // Digit-by-digit step: two radicand bits in, one root bit out.
    always_comb begin
        rem_sh = {r_rem[RW:0], r_rad[VW-1:VW-2]};
        trial  = {1'b0, r_root, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(RW - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[VW-3:0], 2'b00};
            r_rem  <= fits ? rem_sh - trial : rem_sh;
            r_root <= {r_root[RW-2:0], fits};
        end
    end

    assign o_root = r_root;

endmodule

`default_nettype wire
